@@ rtl/generational_key_allocator_macros.svh @@
// Assertion macros for the generational key allocator checker.
// Used by gka_checker; no other dependencies.
`ifndef GENERATIONAL_KEY_ALLOCATOR_MACROS_SVH
`define GENERATIONAL_KEY_ALLOCATOR_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define GKA_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define GKA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/gka_pkg.sv @@
// Package for the generational key allocator: sizes, codes, state and record types.
// No dependencies.
`default_nettype none

package gka_pkg;

    localparam int KEY_COUNT   = 1024;
    localparam int GEN_WIDTH   = 32;
    localparam int VALUE_WIDTH = 64;

    localparam int ID_W  = $clog2(KEY_COUNT);
    localparam int CNT_W = $clog2(KEY_COUNT + 1);

    localparam int KIND_W    = 2;
    localparam int KEY_ID_W  = 10;
    localparam int KEY_GEN_W = 32;
    localparam int VALUE_W   = 64;
    localparam int STATUS_W  = 2;

    localparam logic [KIND_W-1:0] KIND_CREATE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DELETE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_SET    = 2'd2;
    localparam logic [KIND_W-1:0] KIND_GET    = 2'd3;

    localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EINVAL = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EAGAIN = 2'd2;

    localparam logic [GEN_WIDTH-1:0] GEN_MAX        = '1;
    localparam logic [GEN_WIDTH-1:0] GEN_PUSH_LIMIT = GEN_MAX - GEN_WIDTH'(2);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_POP,
        S_EXEC
    } state_t;

    typedef struct packed {
        logic [GEN_WIDTH-1:0]   key_gen;
        logic [GEN_WIDTH-1:0]   slot_gen;
        logic [VALUE_WIDTH-1:0] slot_val;
    } slot_t;

    typedef struct packed {
        logic [KIND_W-1:0]      kind;
        logic [KEY_ID_W-1:0]    key_id;
        logic [GEN_WIDTH-1:0]   key_gen;
        logic [VALUE_WIDTH-1:0] value;
    } req_t;

endpackage

`default_nettype wire

@@ rtl/gka_if.sv @@
// Request and response channel interfaces of the generational key allocator.
// Depends on gka_pkg.
`default_nettype none

interface gka_req_if import gka_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [KIND_W-1:0]    kind;
    logic [KEY_ID_W-1:0]  key_id;
    logic [KEY_GEN_W-1:0] key_gen;
    logic [VALUE_W-1:0]   value;

    modport source (output valid, kind, key_id, key_gen, value, input ready);
    modport sink (input valid, kind, key_id, key_gen, value, output ready);
endinterface

interface gka_resp_if import gka_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [STATUS_W-1:0]  status;
    logic [KEY_ID_W-1:0]  new_id;
    logic [KEY_GEN_W-1:0] new_gen;
    logic                 found;
    logic [VALUE_W-1:0]   read_value;

    modport source (output valid, status, new_id, new_gen, found, read_value, input ready);
    modport sink (input valid, status, new_id, new_gen, found, read_value, output ready);
endinterface

`default_nettype wire

@@ rtl/generational_key_allocator.sv @@
// Generational key allocator top level: slot memory, free-id stack and control.
// Depends on gka_pkg and the channel interfaces in gka_if.sv.
//
// Hands out handles (id, odd generation), checks and retires them, and keeps one
// tagged value per id. Delete, set and get go through the execute state into the
// response register; create first goes through a pop state, as the id popped from
// the free stack must come back from the stack memory before the slot memory can be
// read at it (both memories have a registered read). One request is in flight at a
// time; a finished response waits in the output register, and the next request is
// taken once that register is empty or being emptied. After reset a clearing pass
// zeroes all KEY_COUNT (1024) slot entries, one per cycle, with req.ready held low.
`default_nettype none

module generational_key_allocator
    import gka_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    gka_req_if.sink     req,
    gka_resp_if.source  resp
);

    state_t state_reg, state_next;
    req_t   req_reg;

    logic [CNT_W-1:0] fresh_reg, fresh_next;
    logic [CNT_W-1:0] depth_reg, depth_next;
    logic [ID_W-1:0]  clr_reg;
    logic             clr_last;
    logic [ID_W-1:0]  nid_reg, nid_next;
    logic             fail_reg, fail_next;
    logic             req_fire;

    slot_t           slot_mem [KEY_COUNT];
    slot_t           slot_rd;
    slot_t           slot_wdata;
    logic [ID_W-1:0] slot_raddr, slot_waddr;
    logic            slot_we;

    logic [ID_W-1:0] stack_mem [KEY_COUNT];
    logic [ID_W-1:0] stack_rd, stack_raddr, stack_waddr, stack_wdata;
    logic            stack_we;

    logic                 resp_valid_reg;
    logic                 load_resp;
    logic [STATUS_W-1:0]  status_reg, status_next;
    logic [KEY_ID_W-1:0]  new_id_reg, new_id_next;
    logic [KEY_GEN_W-1:0] new_gen_reg, new_gen_next;
    logic                 found_reg, found_next;
    logic [VALUE_W-1:0]   read_value_reg, read_value_next;

    logic                 odd, id_ok, fresh_ok;
    logic [GEN_WIDTH-1:0] gen_create, gen_delete;

    assign req_fire  = req.valid && req.ready;
    assign req.ready = (state_reg == S_IDLE) && (!resp_valid_reg || resp.ready);
    assign clr_last  = (clr_reg == ID_W'(KEY_COUNT - 1));

    assign resp.valid      = resp_valid_reg;
    assign resp.status     = status_reg;
    assign resp.new_id     = new_id_reg;
    assign resp.new_gen    = new_gen_reg;
    assign resp.found      = found_reg;
    assign resp.read_value = read_value_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                if (clr_last)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (req_fire)
                    state_next = (req.kind == KIND_CREATE) ? S_POP : S_EXEC;
            end
            S_POP:   state_next = S_EXEC;
            S_EXEC:  state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    assign odd        = req_reg.key_gen[0];
    assign id_ok      = 32'(req_reg.key_id) < 32'(KEY_COUNT);
    assign fresh_ok   = 32'(req_reg.key_id) < 32'(fresh_reg);
    assign gen_create = slot_rd.key_gen + GEN_WIDTH'(1);
    assign gen_delete = req_reg.key_gen + GEN_WIDTH'(1);

    assign stack_raddr = ID_W'(depth_reg - CNT_W'(1));
    assign slot_raddr  = (state_reg == S_POP) ? nid_next : ID_W'(req.key_id);

    // datapath and outputs
    always_comb
    begin
        fresh_next      = fresh_reg;
        depth_next      = depth_reg;
        nid_next        = nid_reg;
        fail_next       = fail_reg;
        slot_we         = 1'b0;
        slot_waddr      = ID_W'(req_reg.key_id);
        slot_wdata      = slot_rd;
        stack_we        = 1'b0;
        stack_waddr     = ID_W'(depth_reg);
        stack_wdata     = ID_W'(req_reg.key_id);
        load_resp       = 1'b0;
        status_next     = STATUS_OK;
        new_id_next     = '0;
        new_gen_next    = '0;
        found_next      = 1'b0;
        read_value_next = '0;
        case (state_reg)
            S_CLEAR:
            begin
                slot_we    = 1'b1;
                slot_waddr = clr_reg;
                slot_wdata = '0;
            end
            S_POP:
            begin
                fail_next = 1'b0;
                if (depth_reg != '0)
                begin
                    depth_next = depth_reg - CNT_W'(1);
                    nid_next   = stack_rd;
                end
                else if (fresh_reg < CNT_W'(KEY_COUNT))
                begin
                    nid_next   = ID_W'(fresh_reg);
                    fresh_next = fresh_reg + CNT_W'(1);
                end
                else
                begin
                    nid_next  = '0;
                    fail_next = 1'b1;
                end
            end
            S_EXEC:
            begin
                load_resp = 1'b1;
                case (req_reg.kind)
                    KIND_CREATE:
                    begin
                        if (fail_reg)
                            status_next = STATUS_EAGAIN;
                        else
                        begin
                            slot_we            = 1'b1;
                            slot_waddr         = nid_reg;
                            slot_wdata.key_gen = gen_create;
                            new_id_next        = KEY_ID_W'(nid_reg);
                            new_gen_next       = KEY_GEN_W'(gen_create);
                        end
                    end
                    KIND_DELETE:
                    begin
                        if (!odd || !fresh_ok || !id_ok
                            || slot_rd.key_gen != req_reg.key_gen)
                            status_next = STATUS_EINVAL;
                        else
                        begin
                            slot_we            = 1'b1;
                            slot_wdata.key_gen = gen_delete;
                            if (gen_delete <= GEN_PUSH_LIMIT && depth_reg < CNT_W'(KEY_COUNT))
                            begin
                                stack_we   = 1'b1;
                                depth_next = depth_reg + CNT_W'(1);
                            end
                        end
                    end
                    KIND_SET:
                    begin
                        if (!odd || !id_ok)
                            status_next = STATUS_EINVAL;
                        else
                        begin
                            slot_we             = 1'b1;
                            slot_wdata.slot_gen = req_reg.key_gen;
                            slot_wdata.slot_val = req_reg.value;
                        end
                    end
                    KIND_GET:
                    begin
                        if (!odd || !id_ok)
                            status_next = STATUS_EINVAL;
                        else if (slot_rd.slot_gen == req_reg.key_gen)
                        begin
                            found_next      = 1'b1;
                            read_value_next = VALUE_W'(slot_rd.slot_val);
                        end
                    end
                    default: status_next = STATUS_EINVAL;
                endcase
            end
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            fresh_reg      <= '0;
            depth_reg      <= '0;
            clr_reg        <= '0;
            resp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fresh_reg <= fresh_next;
            depth_reg <= depth_next;
            if (state_reg == S_CLEAR)
                clr_reg <= clr_reg + ID_W'(1);
            if (load_resp)
                resp_valid_reg <= 1'b1;
            else if (resp.ready)
                resp_valid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        nid_reg  <= nid_next;
        fail_reg <= fail_next;
        if (req_fire)
        begin
            req_reg.kind    <= req.kind;
            req_reg.key_id  <= req.key_id;
            req_reg.key_gen <= GEN_WIDTH'(req.key_gen);
            req_reg.value   <= VALUE_WIDTH'(req.value);
        end
        if (load_resp)
        begin
            status_reg     <= status_next;
            new_id_reg     <= new_id_next;
            new_gen_reg    <= new_gen_next;
            found_reg      <= found_next;
            read_value_reg <= read_value_next;
        end
    end

    // slot memory: key generation, value tag and value per id
    always_ff @(posedge clk)
    begin
        if (slot_we)
            slot_mem[slot_waddr] <= slot_wdata;
        slot_rd <= slot_mem[slot_raddr];
    end

    // free-id stack memory
    always_ff @(posedge clk)
    begin
        if (stack_we)
            stack_mem[stack_waddr] <= stack_wdata;
        stack_rd <= stack_mem[stack_raddr];
    end

endmodule

`default_nettype wire

@@ rtl/gka_checker.sv @@
// Port-level checker for the generational key allocator, bound to the top level.
// Depends on gka_pkg and generational_key_allocator_macros.svh.
`default_nettype none

`include "generational_key_allocator_macros.svh"

module gka_checker
    import gka_pkg::*;
(
    input wire logic                 clk,
    input wire logic                 rst_n,
    input wire logic                 resp_valid,
    input wire logic                 resp_ready,
    input wire logic [STATUS_W-1:0]  resp_status,
    input wire logic [KEY_GEN_W-1:0] resp_new_gen,
    input wire logic                 resp_found,
    input wire logic [VALUE_W-1:0]   resp_read_value
);

    `GKA_ASSERT_NEXT(a_resp_hold, clk, rst_n, resp_valid && !resp_ready, resp_valid, "response dropped while stalled")
    `GKA_ASSERT_IMPLY(a_status_code, clk, rst_n, resp_valid, resp_status == STATUS_OK || resp_status == STATUS_EINVAL || resp_status == STATUS_EAGAIN, "undefined status code")
    `GKA_ASSERT_IMPLY(a_error_clean, clk, rst_n, resp_valid && resp_status != STATUS_OK, resp_new_gen == '0 && !resp_found && resp_read_value == '0, "error response carries data")
    `GKA_ASSERT_IMPLY(a_handle_odd, clk, rst_n, resp_valid && resp_new_gen != '0, resp_new_gen[0] && resp_status == STATUS_OK, "created handle has even generation")
    `GKA_ASSERT_IMPLY(a_miss_zero, clk, rst_n, resp_valid && !resp_found, resp_read_value == '0, "value returned without a match")

endmodule

bind generational_key_allocator gka_checker u_gka_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .resp_valid      (resp.valid),
    .resp_ready      (resp.ready),
    .resp_status     (resp.status),
    .resp_new_gen    (resp.new_gen),
    .resp_found      (resp.found),
    .resp_read_value (resp.read_value)
);

`default_nettype wire

@@ dv/generational_key_allocator_test.sv @@
`timescale 1ns / 100ps
// Testbench for generational_key_allocator: directed and random create, delete, set and get
// requests, each response checked against a shadow copy of the id and slot tables.
// Depends on gka_pkg, the channel interfaces in gka_if.sv and the allocator RTL.

module generational_key_allocator_test;
    import gka_pkg::*;

    typedef struct packed {
        logic [STATUS_W-1:0]  status;
        logic [KEY_ID_W-1:0]  new_id;
        logic [KEY_GEN_W-1:0] new_gen;
        logic                 found;
        logic [VALUE_W-1:0]   read_value;
    } reply_t;

    typedef struct {
        logic [KEY_ID_W-1:0]  id;
        logic [KEY_GEN_W-1:0] gen;
    } handle_t;

    class allocator_shadow;
        bit [GEN_WIDTH-1:0]   id_gen_tab [KEY_COUNT];
        bit [GEN_WIDTH-1:0]   slot_tag_tab [KEY_COUNT];
        bit [VALUE_WIDTH-1:0] slot_val_tab [KEY_COUNT];
        bit [ID_W-1:0]        free_ids [$];
        int                   ids_issued;
        reply_t               pending_replies [$];
        int                   mismatches;
        int                   kind_count [4];
        int                   refused;
        int                   reused;
        int                   hits;

        function reply_t note_request(req_t r);
            reply_t             rep;
            bit [GEN_WIDTH-1:0] g;
            rep = '0;
            case (r.kind)
                KIND_CREATE:
                begin
                    if (free_ids.size() > 0)
                    begin
                        rep.new_id = free_ids[free_ids.size() - 1];
                        free_ids.delete(free_ids.size() - 1);
                        reused++;
                    end
                    else if (ids_issued < KEY_COUNT)
                    begin
                        rep.new_id = ID_W'(ids_issued);
                        ids_issued++;
                    end
                    else
                    begin
                        rep.status = STATUS_EAGAIN;
                        refused++;
                    end
                    if (rep.status == STATUS_OK)
                    begin
                        id_gen_tab[rep.new_id] = id_gen_tab[rep.new_id] + 1'b1;
                        rep.new_gen = id_gen_tab[rep.new_id];
                    end
                end
                KIND_DELETE:
                begin
                    g = id_gen_tab[r.key_id];
                    // stored gen must be odd and equal; odd request gen covers both
                    if (!r.key_gen[0] || r.key_id >= ids_issued || g != r.key_gen)
                        rep.status = STATUS_EINVAL;
                    else
                    begin
                        g = g + 1'b1;
                        id_gen_tab[r.key_id] = g;
                        if (g <= GEN_PUSH_LIMIT && free_ids.size() < KEY_COUNT)
                            free_ids.insert(free_ids.size(), r.key_id);
                    end
                end
                KIND_SET:
                begin
                    if (!r.key_gen[0])
                        rep.status = STATUS_EINVAL;
                    else
                    begin
                        slot_tag_tab[r.key_id] = r.key_gen;
                        slot_val_tab[r.key_id] = r.value;
                    end
                end
                default:
                begin
                    if (!r.key_gen[0])
                        rep.status = STATUS_EINVAL;
                    else if (slot_tag_tab[r.key_id] == r.key_gen)
                    begin
                        rep.found = 1'b1;
                        rep.read_value = slot_val_tab[r.key_id];
                        hits++;
                    end
                end
            endcase
            kind_count[r.kind]++;
            pending_replies.insert(pending_replies.size(), rep);
            return rep;
        endfunction

        function void check_response(reply_t got);
            reply_t want;
            if (pending_replies.size() == 0)
            begin
                $error("response with no request outstanding");
                mismatches++;
                return;
            end
            want = pending_replies.pop_front();
            if (got.status !== want.status)
            begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                mismatches++;
            end
            if (got.new_id !== want.new_id)
            begin
                $error("new_id: expected %0d, got %0d", want.new_id, got.new_id);
                mismatches++;
            end
            if (got.new_gen !== want.new_gen)
            begin
                $error("new_gen: expected %0h, got %0h", want.new_gen, got.new_gen);
                mismatches++;
            end
            if (got.found !== want.found)
            begin
                $error("found: expected %0d, got %0d", want.found, got.found);
                mismatches++;
            end
            if (got.read_value !== want.read_value)
            begin
                $error("read_value: expected %0h, got %0h", want.read_value, got.read_value);
                mismatches++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;

    gka_req_if  req_ch();
    gka_resp_if resp_ch();

    generational_key_allocator dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .resp  (resp_ch)
    );

    allocator_shadow shadow;
    handle_t         live [$];
    handle_t         stale [$];
    int              send_idle_pct = 0;
    int              stall_pct = 0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        resp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            resp_ch.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge clk)
        if (rst_n && resp_ch.valid && resp_ch.ready)
            shadow.check_response({resp_ch.status, resp_ch.new_id, resp_ch.new_gen,
                                   resp_ch.found, resp_ch.read_value});

    task automatic send(input logic [KIND_W-1:0] kind, input logic [KEY_ID_W-1:0] id,
                        input logic [KEY_GEN_W-1:0] gen, input logic [VALUE_W-1:0] val);
        req_t   r;
        reply_t rep;
        int     idx;
        r = '{kind, id, gen, val};
        idx = -1;
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid   <= 1'b1;
        req_ch.kind    <= kind;
        req_ch.key_id  <= id;
        req_ch.key_gen <= gen;
        req_ch.value   <= val;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        rep = shadow.note_request(r);
        if (kind == KIND_CREATE && rep.status == STATUS_OK)
            live.insert(live.size(), handle_t'{rep.new_id, rep.new_gen});
        else if (kind == KIND_DELETE && rep.status == STATUS_OK)
        begin
            foreach (live[i])
                if (live[i].id == id)
                    idx = i;
            if (idx >= 0)
                live.delete(idx);
            stale.insert(stale.size(), handle_t'{id, gen});
            if (stale.size() > 32)
                void'(stale.pop_front());
        end
    endtask

    // mostly live handles, some stale ones, the rest random ids and gens
    task automatic random_request(input int create_pct, input int delete_pct);
        int                pick;
        int                mode;
        logic [KIND_W-1:0] kind;
        handle_t           h;
        pick = $urandom_range(99);
        mode = $urandom_range(99);
        h.id = KEY_ID_W'($urandom_range(KEY_COUNT - 1));
        h.gen = $urandom();
        if (pick < create_pct)
            kind = KIND_CREATE;
        else if (pick < create_pct + delete_pct)
            kind = KIND_DELETE;
        else
            kind = $urandom_range(1) ? KIND_SET : KIND_GET;
        if (kind != KIND_CREATE)
        begin
            if (mode < 70 && live.size() > 0)
                h = live[$urandom_range(live.size() - 1)];
            else if (mode < 85 && stale.size() > 0)
                h = stale[$urandom_range(stale.size() - 1)];
        end
        send(kind, h.id, h.gen, {$urandom(), $urandom()});
    endtask

    initial
    begin
        int count;
        shadow = new();
        req_ch.valid   <= 1'b0;
        req_ch.kind    <= KIND_CREATE;
        req_ch.key_id  <= '0;
        req_ch.key_gen <= '0;
        req_ch.value   <= '0;
        rst_n <= 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send(KIND_GET, 0, 1, 0);
        send(KIND_GET, '1, 0, '1);
        send(KIND_DELETE, 0, 1, 0);
        send(KIND_CREATE, 0, 0, 0);
        send(KIND_CREATE, '1, '1, '1);
        send(KIND_SET, 0, 1, '1);
        send(KIND_GET, 0, 1, 0);
        send(KIND_SET, '1, '1, 0);
        send(KIND_GET, '1, '1, 0);
        send(KIND_GET, '1, 32'hFFFF_FFFD, 0);
        send(KIND_SET, 5, 2, 64'h5555_5555_5555_5555);
        send(KIND_DELETE, 0, 3, 0);
        send(KIND_DELETE, 0, 0, 0);
        send(KIND_DELETE, 0, 1, 0);
        send(KIND_DELETE, 0, 1, 0);
        send(KIND_GET, 0, 1, 0);
        send(KIND_CREATE, 0, 0, 0);
        send(KIND_DELETE, 1, 1, 0);
        send(KIND_DELETE, 0, 3, 0);
        send(KIND_CREATE, 0, 0, 0);
        send(KIND_CREATE, 0, 0, 0);
        send(KIND_CREATE, 0, 0, 0);
        send(KIND_DELETE, '1, '1, 0);
        send(KIND_SET, 2, 1, 64'hAAAA_AAAA_AAAA_AAAA);
        send(KIND_GET, 2, 1, 0);

        // phases: no idling, sender idle, receiver stalls, both
        for (int phase = 0; phase < 4; phase++)
        begin
            send_idle_pct = (phase == 1) ? 77 : (phase == 3) ? 25 : 0;
            stall_pct     = (phase == 2) ? 77 : (phase == 3) ? 25 : 0;
            count = 0;
            while (count < 312)
            begin
                // fill the id space until creates get refused, then settle to a mix
                if (shadow.refused > 0)
                    random_request(35, 15);
                else
                    random_request(92, 4);
                count++;
            end
        end
        req_ch.valid <= 1'b0;

        while (shadow.pending_replies.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("Covered %0d create (%0d refused, %0d reused ids), %0d delete, %0d set,",
                 shadow.kind_count[KIND_CREATE], shadow.refused, shadow.reused,
                 shadow.kind_count[KIND_DELETE], shadow.kind_count[KIND_SET]);
        $display("%0d get (%0d hits); %0d ids handed out", shadow.kind_count[KIND_GET],
                 shadow.hits, shadow.ids_issued);
        if (shadow.mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        #5000000;
        $error("timeout");
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+rtl
rtl/gka_pkg.sv
rtl/gka_if.sv
rtl/generational_key_allocator.sv
rtl/gka_checker.sv
dv/generational_key_allocator_test.sv
